FILE: rtl/core/lle_pkg.sv
// shared types and constants for the linked list engine
`timescale 1ns / 1ps
package lle_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [2:0] ACT_INS_FRONT  = 3'd0;
  localparam logic [2:0] ACT_INS_END    = 3'd1;
  localparam logic [2:0] ACT_INS_BEFORE = 3'd2;
  localparam logic [2:0] ACT_INS_AFTER  = 3'd3;
  localparam logic [2:0] ACT_DEL_FRONT  = 3'd4;
  localparam logic [2:0] ACT_DEL_END    = 3'd5;
  localparam logic [2:0] ACT_DEL_VALUE  = 3'd6;
  localparam logic [2:0] ACT_SEARCH     = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_WALK_RD,
    S_WALK_CHK,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_LINK_RD,
    S_LINK_CHK,
    S_COMMIT1,
    S_COMMIT2,
    S_FREE,
    S_DONE
  } state_t;

endpackage

FILE: rtl/core/linked_list_engine.sv
// top level of the linked list engine: control sequencer and both stores
`timescale 1ns / 1ps
// Bounded singly linked list of up to CAPACITY signed values held in a value
// ram and a link ram, each with one write and one registered read port. After
// reset a clearing pass chains the link ram into the free list; no request is
// taken during it. Insert at end into a non-empty list, delete at end and every
// action that matches a target walk the list through the link ram, reading an
// entry in S_WALK_RD and checking it in S_WALK_CHK. One request is worked at a
// time; the result waits in an output register, and the next request is taken
// only when the output is empty or its result is being accepted.
module linked_list_engine #(
  parameter int CAPACITY = lle_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = lle_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic signed [31:0] new_value,
  input  logic signed [31:0] target_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] removed_value,
  output logic [6:0]         found_position
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = AW + 1;
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);

  lle_pkg::state_t state, state_next;

  logic [2:0]            act;
  logic [VALUE_BITS-1:0] nv, tv;
  logic [PW-1:0]         head, free_ptr, cnt;
  logic [PW-1:0]         cur, prev, pos, steps, nidx, cur_link;
  logic [PW-1:0]         init_idx;
  logic                  res_pending;

  logic [2:0]            act_next;
  logic [VALUE_BITS-1:0] nv_next, tv_next;
  logic [PW-1:0]         head_next, free_next, cnt_next;
  logic [PW-1:0]         cur_next, prev_next, pos_next, steps_next, nidx_next;
  logic [PW-1:0]         cur_link_next, init_next;

  logic                  vwe, lwe;
  logic [AW-1:0]         vwaddr, vraddr, lwaddr, lraddr;
  logic [VALUE_BITS-1:0] vwdata, vrdata;
  logic [PW-1:0]         lwdata, lrdata;

  logic                  fin;
  logic [1:0]            fin_status;
  logic [VALUE_BITS-1:0] fin_removed;
  logic                  fin_rm;
  logic [6:0]            fin_pos;

  lle_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_values (
    .clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata), .raddr(vraddr),
    .rdata(vrdata)
  );

  lle_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_links (
    .clk(clk), .we(lwe), .waddr(lwaddr), .wdata(lwdata), .raddr(lraddr),
    .rdata(lrdata)
  );

  function automatic logic [VALUE_BITS-1:0] from_in(input logic [31:0] x);
    logic [63:0] e;
    e = {{32{x[31]}}, x};
    return e[VALUE_BITS-1:0];
  endfunction

  function automatic logic [31:0] to_out(input logic [VALUE_BITS-1:0] x);
    logic [63:0] e;
    e = 64'(signed'(x));
    return e[31:0];
  endfunction

  logic is_match, is_ins;
  assign is_match = (act == lle_pkg::ACT_INS_BEFORE) || (act == lle_pkg::ACT_INS_AFTER) ||
                    (act == lle_pkg::ACT_DEL_VALUE) || (act == lle_pkg::ACT_SEARCH);
  assign is_ins = !act[2];

  assign in_ready = (state == lle_pkg::S_IDLE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lle_pkg::S_INIT;
      head <= NIL;
      free_ptr <= '0;
      cnt <= '0;
      init_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head <= head_next;
      free_ptr <= free_next;
      cnt <= cnt_next;
      init_idx <= init_next;
      if (fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    act <= act_next;
    nv <= nv_next;
    tv <= tv_next;
    cur <= cur_next;
    prev <= prev_next;
    pos <= pos_next;
    steps <= steps_next;
    nidx <= nidx_next;
    cur_link <= cur_link_next;
    if (fin) begin
      status <= fin_status;
      removed_value <= fin_rm ? signed'(to_out(fin_removed)) : '0;
      found_position <= fin_pos;
    end
  end

  assign res_pending = out_valid && !out_ready;

  always_comb begin
    state_next = state;
    act_next = act;
    nv_next = nv;
    tv_next = tv;
    head_next = head;
    free_next = free_ptr;
    cnt_next = cnt;
    cur_next = cur;
    prev_next = prev;
    pos_next = pos;
    steps_next = steps;
    nidx_next = nidx;
    cur_link_next = cur_link;
    init_next = init_idx;
    vwe = 1'b0;
    vwaddr = nidx[AW-1:0];
    vwdata = nv;
    vraddr = cur[AW-1:0];
    lwe = 1'b0;
    lwaddr = init_idx[AW-1:0];
    lwdata = init_idx + 1'b1;
    lraddr = cur[AW-1:0];
    fin = 1'b0;
    fin_status = lle_pkg::ST_OK;
    fin_removed = vrdata;
    fin_rm = 1'b0;
    fin_pos = '0;
    unique case (state)
      lle_pkg::S_INIT: begin
        lwe = 1'b1;
        init_next = init_idx + 1'b1;
        if (init_idx == NIL - 1'b1) begin
          state_next = lle_pkg::S_IDLE;
        end
      end
      lle_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          act_next = action;
          nv_next = from_in(new_value);
          tv_next = from_in(target_value);
          state_next = lle_pkg::S_DISPATCH;
        end
      end
      lle_pkg::S_DISPATCH: begin
        cur_next = head;
        prev_next = NIL;
        pos_next = PW'(1);
        steps_next = '0;
        if (!is_ins && head == NIL) begin
          fin_status = lle_pkg::ST_EMPTY;
          state_next = lle_pkg::S_DONE;
        end else if (is_match && head == NIL) begin
          fin_status = lle_pkg::ST_EMPTY;
          state_next = lle_pkg::S_DONE;
        end else if (is_ins && (cnt == NIL || free_ptr == NIL)) begin
          fin_status = lle_pkg::ST_FULL;
          state_next = lle_pkg::S_DONE;
        end else if (is_match || act == lle_pkg::ACT_DEL_END ||
                     (act == lle_pkg::ACT_INS_END && head != NIL)) begin
          state_next = lle_pkg::S_WALK_RD;
        end else if (is_ins) begin
          state_next = lle_pkg::S_ALLOC_RD;
        end else begin
          state_next = lle_pkg::S_WALK_RD;
        end
        if (state_next == lle_pkg::S_DONE) begin
          fin = 1'b1;
          state_next = res_pending ? lle_pkg::S_DISPATCH : lle_pkg::S_IDLE;
          if (res_pending) begin
            fin = 1'b0;
          end
        end
      end
      lle_pkg::S_WALK_RD: begin
        state_next = lle_pkg::S_WALK_CHK;
      end
      lle_pkg::S_WALK_CHK: begin
        cur_link_next = lrdata;
        if (act == lle_pkg::ACT_DEL_FRONT) begin
          head_next = lrdata;
          nidx_next = cur;
          fin_rm = 1'b1;
          state_next = lle_pkg::S_FREE;
        end else if (is_match) begin
          if (vrdata == tv) begin
            if (act == lle_pkg::ACT_SEARCH) begin
              fin = 1'b1;
              fin_pos = pos[6:0];
              state_next = lle_pkg::S_IDLE;
            end else if (act == lle_pkg::ACT_DEL_VALUE) begin
              if (prev == NIL) begin
                head_next = lrdata;
              end else begin
                lwe = 1'b1;
                lwaddr = prev[AW-1:0];
                lwdata = lrdata;
              end
              nidx_next = cur;
              fin_rm = 1'b1;
              state_next = lle_pkg::S_FREE;
            end else begin
              state_next = lle_pkg::S_ALLOC_RD;
            end
          end else if (lrdata == NIL || steps == NIL - 1'b1) begin
            fin = 1'b1;
            fin_status = lle_pkg::ST_NOT_FOUND;
            state_next = lle_pkg::S_IDLE;
          end else begin
            prev_next = cur;
            cur_next = lrdata;
            pos_next = pos + 1'b1;
            steps_next = steps + 1'b1;
            state_next = lle_pkg::S_WALK_RD;
          end
        end else begin
          if (lrdata == NIL || steps == NIL - 1'b1) begin
            if (act == lle_pkg::ACT_DEL_END) begin
              if (prev == NIL) begin
                head_next = NIL;
              end else begin
                lwe = 1'b1;
                lwaddr = prev[AW-1:0];
                lwdata = NIL;
              end
              nidx_next = cur;
              fin_rm = 1'b1;
              state_next = lle_pkg::S_FREE;
            end else begin
              state_next = lle_pkg::S_ALLOC_RD;
            end
          end else begin
            prev_next = cur;
            cur_next = lrdata;
            steps_next = steps + 1'b1;
            state_next = lle_pkg::S_WALK_RD;
          end
        end
        if (fin_rm) begin
          fin = 1'b1;
        end
      end
      lle_pkg::S_ALLOC_RD: begin
        lraddr = free_ptr[AW-1:0];
        nidx_next = free_ptr;
        state_next = lle_pkg::S_ALLOC_CHK;
      end
      lle_pkg::S_ALLOC_CHK: begin
        free_next = lrdata;
        cnt_next = cnt + 1'b1;
        vwe = 1'b1;
        state_next = lle_pkg::S_COMMIT1;
      end
      lle_pkg::S_COMMIT1: begin
        lwe = 1'b1;
        lwaddr = nidx[AW-1:0];
        unique case (act)
          lle_pkg::ACT_INS_FRONT: begin
            lwdata = head;
            head_next = nidx;
            state_next = lle_pkg::S_LINK_RD;
          end
          lle_pkg::ACT_INS_END: begin
            lwdata = NIL;
            if (head == NIL) begin
              head_next = nidx;
              state_next = lle_pkg::S_LINK_RD;
            end else begin
              state_next = lle_pkg::S_COMMIT2;
            end
          end
          lle_pkg::ACT_INS_BEFORE: begin
            lwdata = cur;
            if (prev == NIL) begin
              head_next = nidx;
              state_next = lle_pkg::S_LINK_RD;
            end else begin
              state_next = lle_pkg::S_COMMIT2;
            end
          end
          default: begin
            lwdata = cur_link;
            state_next = lle_pkg::S_COMMIT2;
          end
        endcase
      end
      lle_pkg::S_COMMIT2: begin
        lwe = 1'b1;
        lwdata = nidx;
        lwaddr = (act == lle_pkg::ACT_INS_BEFORE) ? prev[AW-1:0] : cur[AW-1:0];
        state_next = lle_pkg::S_LINK_RD;
      end
      lle_pkg::S_LINK_RD: begin
        fin = 1'b1;
        state_next = lle_pkg::S_IDLE;
      end
      lle_pkg::S_LINK_CHK: begin
        state_next = lle_pkg::S_IDLE;
      end
      lle_pkg::S_FREE: begin
        lwe = 1'b1;
        lwaddr = nidx[AW-1:0];
        lwdata = free_ptr;
        free_next = nidx;
        if (cnt != '0) begin
          cnt_next = cnt - 1'b1;
        end
        state_next = lle_pkg::S_IDLE;
      end
      lle_pkg::S_DONE: begin
        state_next = lle_pkg::S_IDLE;
      end
      default: begin
        state_next = lle_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/lle_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
module lle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
